FILE: rtl/core/pats_pkg.sv
// Shared types and constants for the per-address traffic statistics block.
package pats_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned COUNTER_BITS_DEF  = 48;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_CNT_W = 48;
  localparam int unsigned ONLINE_W = 7;

  localparam logic [OP_W-1:0] OP_OPEN  = 3'd0;
  localparam logic [OP_W-1:0] OP_CLOSE = 3'd1;
  localparam logic [OP_W-1:0] OP_RECV  = 3'd2;
  localparam logic [OP_W-1:0] OP_SEND  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MODIFY,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/core/per_address_traffic_statistics.sv
// Top level of the per-address traffic statistics block.
//
// One input channel carries events (op, ip_addr, byte_count, now_seconds);
// one output channel returns one result per event. Both use valid/stall:
// a transfer happens at a clock edge with valid high and stall low.
// Records live in two single-port-read memories: an address table walked
// one entry per cycle, and a record memory read, updated and written back.
// An event passes from its transfer through a search that compares table
// entries until a hit (all used entries on a miss), a write-back of the
// record, and the result; a refused or not-found event skips the write-back.
// The block returns to idle after the result transfer, before the next
// event can be taken.
// The address walk sets how long an event takes; one event is handled at a time and
// in_stall stays high from acceptance until the result has been taken.
// Reset (rst, synchronous) empties the table and clears the online count
// and the byte totals; memory contents are not cleared since only entries
// below the fill count are read. While out_stall is high the result holds.
module per_address_traffic_statistics #(
  parameter int unsigned TABLE_ENTRIES = pats_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned COUNTER_BITS  = pats_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pats_pkg::OP_W-1:0]       op,
  input  logic [pats_pkg::ADDR_W-1:0]     ip_addr,
  input  logic [pats_pkg::LEN_W-1:0]      byte_count,
  input  logic [pats_pkg::TIME_W-1:0]     now_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pats_pkg::STATUS_W-1:0]   status,
  output logic                            entry_is_online,
  output logic [pats_pkg::OUT_CNT_W-1:0]  entry_bytes_sent,
  output logic [pats_pkg::OUT_CNT_W-1:0]  entry_bytes_received,
  output logic [pats_pkg::TIME_W-1:0]     entry_duration,
  output logic [pats_pkg::ONLINE_W-1:0]   online_count,
  output logic [pats_pkg::OUT_CNT_W-1:0]  sum_bytes_sent,
  output logic [pats_pkg::OUT_CNT_W-1:0]  sum_bytes_received
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TW    = pats_pkg::TIME_W;
  // Record layout: {online, start, duration, sent, received}.
  localparam int unsigned RCV_LO = 0;
  localparam int unsigned SNT_LO = COUNTER_BITS;
  localparam int unsigned DUR_LO = 2 * COUNTER_BITS;
  localparam int unsigned STA_LO = DUR_LO + TW;
  localparam int unsigned ONL_B  = STA_LO + TW;
  localparam int unsigned REC_W  = ONL_B + 1;
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);

  pats_pkg::state_t state, state_next;

  logic [pats_pkg::ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
  logic [REC_W-1:0]            rec_mem  [TABLE_ENTRIES];
  logic [pats_pkg::ADDR_W-1:0] addr_q;
  logic [REC_W-1:0]            rec_q;

  logic [pats_pkg::OP_W-1:0]   op_k;
  logic [pats_pkg::ADDR_W-1:0] key;
  logic [pats_pkg::LEN_W-1:0]  len_k;
  logic [TW-1:0]               now_k;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            slot;
  logic                        new_rec;
  logic [CNT_W-1:0]            slots_used;
  logic [CNT_W-1:0]            online_total;
  logic [COUNTER_BITS-1:0]     sent_total;
  logic [COUNTER_BITS-1:0]     received_total;

  logic                        in_xfer, out_xfer;
  logic                        is_query, hit, last;
  logic [IDX_W-1:0]            rd_idx;

  // Record update signals.
  logic [REC_W-1:0]            rec_old, rec_new;
  logic                        onl_old, onl_new;
  logic [TW-1:0]               sta_new, dur_new;
  logic [COUNTER_BITS-1:0]     snt_new, rcv_new, len_ext;
  logic [CNT_W-1:0]            online_next;
  logic [COUNTER_BITS-1:0]     sent_total_next, received_total_next;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (state != pats_pkg::ST_IDLE);

  assign is_query = (op_k >= pats_pkg::OP_QUERY);
  assign hit      = (slots_used != '0) && (addr_q == key);
  assign last     = (slots_used == '0) || ((CNT_W'(idx) + CNT_W'(1)) == slots_used);
  assign rd_idx   = (state == pats_pkg::ST_SEARCH) ? IDX_W'(idx + IDX_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pats_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pats_pkg::ST_IDLE: begin
        if (in_xfer) state_next = pats_pkg::ST_SEARCH;
      end
      pats_pkg::ST_SEARCH: begin
        if (hit) begin
          state_next = pats_pkg::ST_MODIFY;
        end else if (last) begin
          if (!is_query && slots_used < ENTRIES_C) state_next = pats_pkg::ST_MODIFY;
          else state_next = pats_pkg::ST_OUT;
        end
      end
      pats_pkg::ST_MODIFY: state_next = pats_pkg::ST_OUT;
      pats_pkg::ST_OUT: begin
        if (out_xfer) state_next = pats_pkg::ST_IDLE;
      end
      default: state_next = pats_pkg::ST_IDLE;
    endcase
  end

  // Apply the event to the record; a new record starts from all zeros.
  assign rec_old = new_rec ? '0 : rec_q;
  assign onl_old = rec_old[ONL_B];
  assign len_ext = COUNTER_BITS'(len_k);

  always_comb begin
    onl_new = onl_old;
    sta_new = rec_old[STA_LO +: TW];
    dur_new = rec_old[DUR_LO +: TW];
    snt_new = rec_old[SNT_LO +: COUNTER_BITS];
    rcv_new = rec_old[RCV_LO +: COUNTER_BITS];
    sent_total_next = sent_total;
    received_total_next = received_total;
    unique case (op_k)
      pats_pkg::OP_OPEN: begin
        onl_new = 1'b1;
        sta_new = now_k;
      end
      pats_pkg::OP_CLOSE: begin
        onl_new = 1'b0;
        dur_new = (sta_new != '0) ? TW'(now_k - sta_new) : '0;
      end
      pats_pkg::OP_RECV: begin
        onl_new = 1'b1;
        rcv_new = COUNTER_BITS'(rcv_new + len_ext);
        received_total_next = COUNTER_BITS'(received_total + len_ext);
      end
      pats_pkg::OP_SEND: begin
        onl_new = 1'b1;
        snt_new = COUNTER_BITS'(snt_new + len_ext);
        sent_total_next = COUNTER_BITS'(sent_total + len_ext);
      end
      default: ;
    endcase
    online_next = online_total;
    if (onl_new && !onl_old) begin
      online_next = CNT_W'(online_total + CNT_W'(1));
    end else if (!onl_new && onl_old && online_total != '0) begin
      online_next = CNT_W'(online_total - CNT_W'(1));
    end
    rec_new = {onl_new, sta_new, dur_new, snt_new, rcv_new};
  end

  // Memories: registered reads, one write port each.
  always_ff @(posedge clk) begin
    addr_q <= addr_mem[rd_idx];
    rec_q  <= rec_mem[idx];
    if (state == pats_pkg::ST_SEARCH && !hit && last && !is_query
        && slots_used < ENTRIES_C) begin
      addr_mem[slots_used[IDX_W-1:0]] <= key;
    end
    if (state == pats_pkg::ST_MODIFY) begin
      rec_mem[slot] <= rec_new;
    end
  end

  // Control counters and running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used     <= '0;
      online_total   <= '0;
      sent_total     <= '0;
      received_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == pats_pkg::ST_SEARCH && !hit && last && !is_query
          && slots_used < ENTRIES_C) begin
        slots_used <= CNT_W'(slots_used + CNT_W'(1));
      end
      if (state == pats_pkg::ST_MODIFY) begin
        online_total   <= online_next;
        sent_total     <= sent_total_next;
        received_total <= received_total_next;
      end
      if (state_next == pats_pkg::ST_OUT && state != pats_pkg::ST_OUT) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_k  <= op;
      key   <= ip_addr;
      len_k <= byte_count;
      now_k <= now_seconds;
      idx   <= '0;
    end else if (state == pats_pkg::ST_SEARCH && !hit && !last) begin
      idx <= IDX_W'(idx + IDX_W'(1));
    end
    if (state == pats_pkg::ST_SEARCH) begin
      new_rec <= !hit;
      slot    <= hit ? idx : slots_used[IDX_W-1:0];
      if (!hit && last) begin
        status               <= is_query ? pats_pkg::STATUS_NOT_FOUND
                                         : pats_pkg::STATUS_FULL;
        entry_is_online      <= 1'b0;
        entry_bytes_sent     <= '0;
        entry_bytes_received <= '0;
        entry_duration       <= '0;
        online_count         <= pats_pkg::ONLINE_W'(online_total);
        sum_bytes_sent       <= pats_pkg::OUT_CNT_W'(sent_total);
        sum_bytes_received   <= pats_pkg::OUT_CNT_W'(received_total);
      end
    end
    if (state == pats_pkg::ST_MODIFY) begin
      status               <= pats_pkg::STATUS_OK;
      entry_is_online      <= onl_new;
      entry_bytes_sent     <= pats_pkg::OUT_CNT_W'(snt_new);
      entry_bytes_received <= pats_pkg::OUT_CNT_W'(rcv_new);
      entry_duration       <= dur_new;
      online_count         <= pats_pkg::ONLINE_W'(online_next);
      sum_bytes_sent       <= pats_pkg::OUT_CNT_W'(sent_total_next);
      sum_bytes_received   <= pats_pkg::OUT_CNT_W'(received_total_next);
    end
  end

endmodule

FILE: rtl/core/pats_checker.sv
// Port-level checks for the per-address traffic statistics block.
module pats_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pats_pkg::STATUS_W-1:0]  status,
  input logic                           entry_is_online,
  input logic [pats_pkg::OUT_CNT_W-1:0] entry_bytes_sent,
  input logic [pats_pkg::TIME_W-1:0]    entry_duration
);

  // A result waiting for transfer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One event at a time: no new input while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  // A result never appears in the cycle right after an input transfer.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // Refused or missing addresses report an empty record.
  a_empty_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pats_pkg::STATUS_OK |->
      !entry_is_online && entry_bytes_sent == '0 && entry_duration == '0)
    else $error("entry fields set on a failed event");

endmodule

bind per_address_traffic_statistics pats_checker u_pats_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .entry_is_online (entry_is_online),
  .entry_bytes_sent(entry_bytes_sent),
  .entry_duration  (entry_duration)
);

FILE: test/per_address_traffic_statistics_tb.sv
// Testbench for the per-address traffic statistics block: table-driven and random events.
module per_address_traffic_statistics_tb;

  localparam int unsigned SLOTS = pats_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned N_RANDOM = 1930;

  typedef struct packed {
    logic [pats_pkg::OP_W-1:0]     op;
    logic [pats_pkg::ADDR_W-1:0]   addr;
    logic [pats_pkg::LEN_W-1:0]    len;
    logic [pats_pkg::TIME_W-1:0]   now;
  } event_t;

  typedef struct packed {
    logic [pats_pkg::STATUS_W-1:0]  status;
    logic                           online;
    logic [pats_pkg::OUT_CNT_W-1:0] sent;
    logic [pats_pkg::OUT_CNT_W-1:0] received;
    logic [pats_pkg::TIME_W-1:0]    duration;
    logic [pats_pkg::ONLINE_W-1:0]  online_count;
    logic [pats_pkg::OUT_CNT_W-1:0] sum_sent;
    logic [pats_pkg::OUT_CNT_W-1:0] sum_received;
  } answer_t;

  typedef struct packed {
    event_t  ev;
    logic    has_answer;
    answer_t answer;
  } row_t;

  localparam answer_t NO_ANSWER = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [pats_pkg::OP_W-1:0] op = '0;
  logic [pats_pkg::ADDR_W-1:0] ip_addr = '0;
  logic [pats_pkg::LEN_W-1:0] byte_count = '0;
  logic [pats_pkg::TIME_W-1:0] now_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [pats_pkg::STATUS_W-1:0] status;
  logic entry_is_online;
  logic [pats_pkg::OUT_CNT_W-1:0] entry_bytes_sent, entry_bytes_received;
  logic [pats_pkg::TIME_W-1:0] entry_duration;
  logic [pats_pkg::ONLINE_W-1:0] online_count;
  logic [pats_pkg::OUT_CNT_W-1:0] sum_bytes_sent, sum_bytes_received;

  per_address_traffic_statistics DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the record table and running totals.
  logic [pats_pkg::ADDR_W-1:0]    rec_addr     [SLOTS];
  logic                           rec_online   [SLOTS];
  logic [pats_pkg::TIME_W-1:0]    rec_start    [SLOTS];
  logic [pats_pkg::TIME_W-1:0]    rec_duration [SLOTS];
  logic [pats_pkg::OUT_CNT_W-1:0] rec_sent     [SLOTS];
  logic [pats_pkg::OUT_CNT_W-1:0] rec_received [SLOTS];
  int unsigned                    recs_used;
  logic [pats_pkg::ONLINE_W-1:0]  online_now;
  logic [pats_pkg::OUT_CNT_W-1:0] sent_sum, received_sum;

  answer_t pending_answers[$];
  bit failed = 1'b0;

  function automatic answer_t apply_event(event_t ev);
    answer_t a;
    int slot;
    logic [pats_pkg::OP_W-1:0] code;
    a = '0;
    slot = -1;
    code = (ev.op > pats_pkg::OP_QUERY) ? pats_pkg::OP_QUERY : ev.op;
    for (int i = 0; i < recs_used; i++)
      if (slot < 0 && rec_addr[i] == ev.addr) slot = i;
    if (slot < 0 && code != pats_pkg::OP_QUERY) begin
      if (recs_used < SLOTS) begin
        slot = recs_used;
        recs_used++;
        rec_addr[slot] = ev.addr;
        rec_online[slot] = 1'b0;
        rec_start[slot] = '0;
        rec_duration[slot] = '0;
        rec_sent[slot] = '0;
        rec_received[slot] = '0;
      end else begin
        a.status = pats_pkg::STATUS_FULL;
      end
    end else if (slot < 0) begin
      a.status = pats_pkg::STATUS_NOT_FOUND;
    end
    if (slot >= 0) begin
      if (code == pats_pkg::OP_CLOSE) begin
        if (rec_online[slot]) online_now--;
        rec_online[slot] = 1'b0;
        rec_duration[slot] = (rec_start[slot] != 0) ? ev.now - rec_start[slot] : '0;
      end else if (code != pats_pkg::OP_QUERY) begin
        if (!rec_online[slot]) online_now++;
        rec_online[slot] = 1'b1;
      end
      case (code)
        pats_pkg::OP_OPEN: rec_start[slot] = ev.now;
        pats_pkg::OP_RECV: begin
          rec_received[slot] += ev.len;
          received_sum += ev.len;
        end
        pats_pkg::OP_SEND: begin
          rec_sent[slot] += ev.len;
          sent_sum += ev.len;
        end
        default: ;
      endcase
      a.online = rec_online[slot];
      a.sent = rec_sent[slot];
      a.received = rec_received[slot];
      a.duration = rec_duration[slot];
    end
    a.online_count = online_now;
    a.sum_sent = sent_sum;
    a.sum_received = received_sum;
    return a;
  endfunction

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Drive one event and wait for its transfer. Valid stays high into the
  // next event when there is no gap.
  task automatic send_event(event_t ev, logic has_answer, answer_t answer);
    answer_t predicted;
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= ev.op;
    ip_addr <= ev.addr;
    byte_count <= ev.len;
    now_seconds <= ev.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_event(ev);
    if (has_answer && predicted != answer) begin
      $display("%0t: predictor disagrees with table row: table %h predictor %h",
               $time, answer, predicted);
      failed = 1'b1;
    end
    pending_answers.push_back(has_answer ? answer : predicted);
  endtask

  // Result side: random stall, compare each transfer.
  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          failed = 1'b1;
        end else begin
          want = pending_answers.pop_front();
          if (want.status != status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            failed = 1'b1;
          end
          if (want.online != entry_is_online) begin
            $display("%0t: entry_is_online expected %0d actual %0d",
                     $time, want.online, entry_is_online);
            failed = 1'b1;
          end
          if (want.sent != entry_bytes_sent) begin
            $display("%0t: entry_bytes_sent expected %0d actual %0d",
                     $time, want.sent, entry_bytes_sent);
            failed = 1'b1;
          end
          if (want.received != entry_bytes_received) begin
            $display("%0t: entry_bytes_received expected %0d actual %0d",
                     $time, want.received, entry_bytes_received);
            failed = 1'b1;
          end
          if (want.duration != entry_duration) begin
            $display("%0t: entry_duration expected %0d actual %0d",
                     $time, want.duration, entry_duration);
            failed = 1'b1;
          end
          if (want.online_count != online_count) begin
            $display("%0t: online_count expected %0d actual %0d",
                     $time, want.online_count, online_count);
            failed = 1'b1;
          end
          if (want.sum_sent != sum_bytes_sent) begin
            $display("%0t: sum_bytes_sent expected %0d actual %0d",
                     $time, want.sum_sent, sum_bytes_sent);
            failed = 1'b1;
          end
          if (want.sum_received != sum_bytes_received) begin
            $display("%0t: sum_bytes_received expected %0d actual %0d",
                     $time, want.sum_received, sum_bytes_received);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Stall pattern: bursts of open flow mixed with random holds.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= gap_length();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic event_t make_event(logic [pats_pkg::OP_W-1:0] code,
                                        logic [pats_pkg::ADDR_W-1:0] addr,
                                        logic [pats_pkg::LEN_W-1:0] len,
                                        logic [pats_pkg::TIME_W-1:0] now);
    event_t ev;
    ev.op = code;
    ev.addr = addr;
    ev.len = len;
    ev.now = now;
    return ev;
  endfunction

  function automatic answer_t totals_only(logic [pats_pkg::STATUS_W-1:0] st);
    answer_t a;
    a = '0;
    a.status = st;
    return a;
  endfunction

  row_t directed[$];
  logic [pats_pkg::ADDR_W-1:0] pool[$];

  initial begin
    event_t ev;
    logic [pats_pkg::OP_W-1:0] code;
    logic [pats_pkg::ADDR_W-1:0] addr;
    int unsigned r;

    for (int i = 0; i < SLOTS; i++) begin
      rec_addr[i] = '0;
      rec_online[i] = 1'b0;
      rec_start[i] = '0;
      rec_duration[i] = '0;
      rec_sent[i] = '0;
      rec_received[i] = '0;
    end
    recs_used = 0;
    online_now = '0;
    sent_sum = '0;
    received_sum = '0;

    // Query of an absent address on an empty table, then the extremes.
    directed.push_back({make_event(pats_pkg::OP_QUERY, 32'h0A00_0001, 16'hFFFF, 32'hFFFF_FFFF),
                        1'b1, totals_only(pats_pkg::STATUS_NOT_FOUND)});
    directed.push_back({make_event(3'd7, 32'hFFFF_FFFF, 16'h0, 32'h0),
                        1'b1, totals_only(pats_pkg::STATUS_NOT_FOUND)});
    // Close of a record never opened gives duration zero.
    directed.push_back({make_event(pats_pkg::OP_CLOSE, 32'hFFFF_FFFF, 16'h0, 32'd500), 1'b1,
                        totals_only(pats_pkg::STATUS_OK)});
    directed.push_back({make_event(pats_pkg::OP_OPEN, 32'h0, 16'h0, 32'd0), 1'b0, NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_CLOSE, 32'h0, 16'h0, 32'd77), 1'b0,
                        NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_OPEN, 32'hC0A8_0001, 16'h0, 32'hFFFF_FFF0),
                        1'b0, NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_OPEN, 32'hC0A8_0001, 16'h0, 32'hFFFF_FFF0),
                        1'b0, NO_ANSWER});
    // Elapsed time wraps around 32 bits.
    directed.push_back({make_event(pats_pkg::OP_CLOSE, 32'hC0A8_0001, 16'h0, 32'd16), 1'b0,
                        NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_RECV, 32'hC0A8_0002, 16'hFFFF, 32'd1), 1'b0,
                        NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_SEND, 32'hC0A8_0002, 16'hFFFF, 32'd1), 1'b0,
                        NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_SEND, 32'hC0A8_0002, 16'h0, 32'd2), 1'b0,
                        NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_QUERY, 32'hC0A8_0002, 16'h1234, 32'd3), 1'b0,
                        NO_ANSWER});
    directed.push_back({make_event(3'd5, 32'hC0A8_0001, 16'h0, 32'd3), 1'b0, NO_ANSWER});
    directed.push_back({make_event(3'd6, 32'hFFFF_FFFF, 16'h0, 32'd3), 1'b0, NO_ANSWER});
    directed.push_back({make_event(pats_pkg::OP_CLOSE, 32'hC0A8_0002, 16'hAAAA, 32'h5555_5555),
                        1'b0, NO_ANSWER});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_event(directed[i].ev, directed[i].has_answer,
                                     directed[i].answer);
    foreach (rec_addr[i]) if (i < recs_used) pool.push_back(rec_addr[i]);

    // Random events over an address pool that grows to eight more addresses
    // than the table holds, so the table fills and fresh addresses then meet full-table refusals.
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8 || pool.size() == 0) begin
        addr = $urandom();
        if (pool.size() < SLOTS + 8) pool.push_back(addr);
      end else begin
        addr = pool[$urandom_range(0, pool.size() - 1)];
      end
      r = $urandom_range(0, 99);
      if (r < 20) code = pats_pkg::OP_OPEN;
      else if (r < 38) code = pats_pkg::OP_CLOSE;
      else if (r < 60) code = pats_pkg::OP_RECV;
      else if (r < 82) code = pats_pkg::OP_SEND;
      else if (r < 96) code = pats_pkg::OP_QUERY;
      else code = pats_pkg::OP_W'($urandom_range(5, 7));
      ev = make_event(code, addr,
                      ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                  : pats_pkg::LEN_W'($urandom()),
                      ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom());
      send_event(ev, 1'b0, NO_ANSWER);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
